[rtl/emp_pkg.sv]
// shared types and constants for the expanded memory page mapper
// no dependencies
package emp_pkg;

  localparam int unsigned STORE_BYTES_DEF = 1048576;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned PAGE_SHIFT = 14;
  localparam int unsigned BYTE_AW    = 8 + PAGE_SHIFT;

  localparam logic [15:0] IO_BASE_RST      = 16'h0260;
  localparam logic [31:0] WINDOW_BASE_RST  = 32'h000D_0000;
  localparam logic [20:0] BACKING_SIZE_RST = 21'h10_0000;

  // configuration register indexes
  localparam logic [1:0] CFG_IO_BASE      = 2'd0;
  localparam logic [1:0] CFG_WINDOW_BASE  = 2'd1;
  localparam logic [1:0] CFG_BACKING_SIZE = 2'd2;

  typedef enum logic [1:0] {
    FUNC_MEM_RD  = 2'd0,
    FUNC_MEM_WR  = 2'd1,
    FUNC_PORT_RD = 2'd2,
    FUNC_PORT_WR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OP_DONE   = 2'd0,
    OP_MEM_RD = 2'd1,
    OP_MEM_WR = 2'd2
  } op_e;

  typedef struct packed {
    logic [15:0] io_base;
    logic [31:0] window_base;
    logic [20:0] backing_size;
  } cfg_t;

  // one classified access on its way to the back end
  typedef struct packed {
    op_e                  op;
    logic                 claimed;
    logic [BYTE_AW-1:0]   addr;
    logic [7:0]           data;
  } entry_t;

endpackage

[rtl/emp_ram.sv]
// generic single port ram with registered read
// no dependencies
module emp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/emp_front.sv]
// front end: decodes an access, owns the page registers, builds a queue entry
// depends on emp_pkg
module emp_front #(
  parameter int unsigned STORE_BYTES = emp_pkg::STORE_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [1:0]     func_i,
  input  logic [31:0]    mem_address_i,
  input  logic [15:0]    io_port_i,
  input  logic [7:0]     data_in_i,
  input  emp_pkg::cfg_t  cfg_i,
  output emp_pkg::entry_t entry_o
);
  import emp_pkg::*;

  localparam logic [BYTE_AW:0] StoreLimit = (BYTE_AW+1)'(STORE_BYTES);

  logic [7:0]          page_q [4];
  logic [31:0]         win_off;
  logic                in_win;
  logic [BYTE_AW-1:0]  byte_addr;
  logic                mem_ok;
  logic [15:0]         port_off;
  logic                port_hit;
  logic [1:0]          slot;
  logic                page_we;
  func_e               func;

  always_comb begin
    win_off   = mem_address_i - cfg_i.window_base;
    in_win    = (mem_address_i >= cfg_i.window_base) && (win_off[31:16] == '0);
    byte_addr = {page_q[win_off[15:14]], win_off[PAGE_SHIFT-1:0]};
    mem_ok    = in_win
             && ({1'b0, byte_addr} < (BYTE_AW+1)'(cfg_i.backing_size))
             && ({1'b0, byte_addr} < StoreLimit);
    port_off  = io_port_i - cfg_i.io_base;
    port_hit  = (io_port_i >= cfg_i.io_base) && (port_off[15:2] == '0);
    slot      = port_off[1:0];
  end

  always_comb begin
    func            = func_e'(func_i);
    entry_o.op      = OP_DONE;
    entry_o.claimed = 1'b0;
    entry_o.addr    = byte_addr;
    entry_o.data    = '0;
    page_we         = 1'b0;
    case (func)
      FUNC_MEM_RD: begin
        entry_o.op      = mem_ok ? OP_MEM_RD : OP_DONE;
        entry_o.claimed = mem_ok;
      end
      FUNC_MEM_WR: begin
        entry_o.op      = mem_ok ? OP_MEM_WR : OP_DONE;
        entry_o.claimed = mem_ok;
        entry_o.data    = mem_ok ? data_in_i : '0;
      end
      FUNC_PORT_RD: begin
        entry_o.claimed = port_hit;
        entry_o.data    = port_hit ? page_q[slot] : '0;
      end
      FUNC_PORT_WR: begin
        entry_o.claimed = port_hit;
        page_we         = port_hit;
      end
      default: begin
        entry_o.op = OP_DONE;
      end
    endcase
  end

  // page registers change in access order, so later accesses see the update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        page_q[i] <= '0;
      end
    end else if (accept_i && page_we) begin
      page_q[slot] <= data_in_i;
    end
  end

endmodule

[rtl/emp_queue.sv]
// short fifo of classified accesses between front and back end
// depends on emp_pkg; depth must be a power of two
module emp_queue #(
  parameter int unsigned DEPTH = emp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  emp_pkg::entry_t entry_i,
  input  logic            pop_i,
  output emp_pkg::entry_t entry_o,
  output logic            empty_o,
  output logic            full_o
);
  import emp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t        slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && !empty_o)) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i && !empty_o) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

[rtl/emp_back.sv]
// back end: runs backing store accesses and drives the result strobe
// depends on emp_pkg and emp_ram
module emp_back #(
  parameter int unsigned STORE_BYTES = emp_pkg::STORE_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  emp_pkg::entry_t entry_i,
  output logic            valid_o,
  output logic            claimed_o,
  output logic [7:0]      read_data_o
);
  import emp_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);

  logic       valid_q;
  logic       claimed_q;
  logic       from_ram_q;
  logic [7:0] data_q;
  logic       ram_en;
  logic       ram_we;
  logic [7:0] ram_rdata;

  assign ram_en = take_i && ((entry_i.op == OP_MEM_RD) || (entry_i.op == OP_MEM_WR));
  assign ram_we = (entry_i.op == OP_MEM_WR);

  emp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (entry_i.addr[AW-1:0]),
    .wdata_i (entry_i.data),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      claimed_q  <= entry_i.claimed;
      from_ram_q <= (entry_i.op == OP_MEM_RD);
      data_q     <= (entry_i.op == OP_MEM_WR) ? '0 : entry_i.data;
    end
  end

  assign valid_o     = valid_q;
  assign claimed_o   = claimed_q;
  assign read_data_o = from_ram_q ? ram_rdata : data_q;

endmodule

[rtl/expanded_memory_page_mapper.sv]
// top level of the expanded memory page mapper
// depends on emp_pkg, emp_front, emp_queue, emp_back
//
//  channel    signals                                          transfer when
//  ---------  -----------------------------------------------  ---------------------
//  access in  start_i busy_o func_i mem_address_i io_port_i    start_i && !busy_o
//             data_in_i
//  result     valid_o claimed_o read_data_o                    valid_o (one cycle)
//  config     cfg_we_i cfg_index_i cfg_wdata_i                 cfg_we_i
//
//  one access per cycle while busy_o is low; results pass queue and back end
//  the backing store read is one ram port, registered, one access per cycle
//  page registers update at accept, so a later access sees them at once
//  reset clears control, config and page registers; the store is not cleared
//  the back end retires one entry every cycle, so busy_o only guards the queue
module expanded_memory_page_mapper #(
  parameter int unsigned STORE_BYTES = emp_pkg::STORE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] mem_address_i,
  input  logic [15:0] io_port_i,
  input  logic [7:0]  data_in_i,
  output logic        valid_o,
  output logic        claimed_o,
  output logic [7:0]  read_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);
  import emp_pkg::*;

  cfg_t   cfg_q;
  entry_t front_entry;
  entry_t head_entry;
  logic   accept;
  logic   q_empty;
  logic   q_full;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.io_base      <= IO_BASE_RST;
      cfg_q.window_base  <= WINDOW_BASE_RST;
      cfg_q.backing_size <= BACKING_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IO_BASE:      cfg_q.io_base      <= cfg_wdata_i[15:0];
        CFG_WINDOW_BASE:  cfg_q.window_base  <= cfg_wdata_i;
        CFG_BACKING_SIZE: cfg_q.backing_size <= cfg_wdata_i[20:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // an access transfers when the queue has room
  assign busy_o = q_full;
  assign accept = start_i && !q_full;

  emp_front #(
    .STORE_BYTES (STORE_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .func_i        (func_i),
    .mem_address_i (mem_address_i),
    .io_port_i     (io_port_i),
    .data_in_i     (data_in_i),
    .cfg_i         (cfg_q),
    .entry_o       (front_entry)
  );

  emp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .entry_i (front_entry),
    .pop_i   (!q_empty),
    .entry_o (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back end takes the head entry whenever there is one
  emp_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (!q_empty),
    .entry_i     (head_entry),
    .valid_o     (valid_o),
    .claimed_o   (claimed_o),
    .read_data_o (read_data_o)
  );

endmodule

[rtl/emp_checker.sv]
// port level checks for the expanded memory page mapper, bound to the top
// depends on expanded_memory_page_mapper
module emp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       valid_o,
  input logic       claimed_o,
  input logic [7:0] read_data_o
);

  // an unclaimed access never returns data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !claimed_o |-> read_data_o == 8'h00)
    else $error("unclaimed result carries data");

  // every accepted access gives its result once it passes the queue and back end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 valid_o)
    else $error("result missing after accepted access");

  // no result without an earlier accepted access
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an access");

endmodule

bind expanded_memory_page_mapper emp_checker u_emp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .valid_o     (valid_o),
  .claimed_o   (claimed_o),
  .read_data_o (read_data_o)
);
